[src/hufd_pkg.sv]
// Shared types and constants for the Huffman tree-walk decoder.
// No dependencies; imported by the top level and the checker.
`default_nettype none

package hufd_pkg;

    localparam int IDX_W = 9;
    localparam int SYM_W = 8;
    localparam int CNT_W = 32;
    localparam int BIT_CNT_W = 3;

    // One stored tree node
    typedef struct packed {
        logic             leaf;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic [SYM_W-1:0] sym;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_CUR,
        ST_WALK,
        ST_FLUSH
    } t_state;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic REG_ROOT  = 1'b0;
    localparam logic REG_TOTAL = 1'b1;

    localparam logic [SYM_W-1:0] CODE_MSB = 8'h80;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT = 3'd7;

endpackage

`default_nettype wire

[src/hufd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hufd_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 512
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/huffman_tree_walk_decoder.sv]
// Huffman tree-walk decoder top level: node table, walk sequencer, APB registers.
// Depends on hufd_pkg and hufd_ram.
//
// Usage:
//   Input channel: start/busy command beats. A beat is taken when start is
//   high and busy is low. i_operation = load writes one tree node from
//   i_node_index/i_node_is_leaf/i_left_index/i_right_index/i_leaf_symbol and
//   busy stays low. i_operation = decode takes i_code_byte.
//   Decode: busy stays high through root fetch, current node fetch, eight bit
//   steps and one flush; if the count reaches the total mid-byte the
//   flush follows that bit at once, and if the stream is already finished
//   the root fetch returns straight to idle. The node table is the only memory and has one
//   read port, so each code bit costs one dependent table read; the next
//   child address is formed straight from the read data, giving one bit
//   per cycle.
//   Result channel: o_valid marks one symbol beat for exactly one cycle, with
//   o_last_of_byte and o_stream_done. The receiver cannot stall; beats go out
//   at most one per cycle. A symbol is held one step so it can be tagged
//   last-of-byte; the byte's final beat is out the cycle after flush.
//   Config: APB, root_node at 0x0, total_symbols at 0x4. Writing either
//   returns the walk to the root and clears the symbol count. Write only
//   while busy is low.
//   Reset (synchronous, active low): idle, root 0, total 0, count 0. The
//   node table is not cleared; entries must be loaded before they are walked.
`default_nettype none

module huffman_tree_walk_decoder
    import hufd_pkg::*;
#(
    parameter int NODE_COUNT = 512
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // command channel
    input  wire               start,
    output logic              busy,
    input  wire               i_operation,
    input  wire [IDX_W-1:0]   i_node_index,
    input  wire               i_node_is_leaf,
    input  wire [IDX_W-1:0]   i_left_index,
    input  wire [IDX_W-1:0]   i_right_index,
    input  wire [SYM_W-1:0]   i_leaf_symbol,
    input  wire [SYM_W-1:0]   i_code_byte,
    // result channel
    output logic              o_valid,
    output logic [SYM_W-1:0]  o_symbol,
    output logic              o_last_of_byte,
    output logic              o_stream_done,
    // APB config
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [2:0]         paddr,
    input  wire [31:0]        pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int AW = $clog2(NODE_COUNT);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_root;
    logic [CNT_W-1:0]   r_total;
    logic [IDX_W-1:0]   r_walk, n_walk;
    logic [CNT_W-1:0]   r_count, n_count;
    t_node              r_root_nd, n_root_nd;
    logic [SYM_W-1:0]   r_byte, n_byte;
    logic [BIT_CNT_W-1:0] r_bits, n_bits;
    logic               r_rd_oob, n_rd_oob;
    // one-deep hold for the latest symbol so it can be tagged last-of-byte
    logic               r_pend_v, n_pend_v;
    logic [SYM_W-1:0]   r_pend_sym, n_pend_sym;
    logic               r_pend_done, n_pend_done;
    logic               n_o_valid;
    logic [SYM_W-1:0]   n_o_symbol;
    logic               n_o_last, n_o_done;

    logic               cfg_wr;
    logic               cfg_idx;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [NODE_W-1:0]  ram_rdata;
    logic [31:0]        wr_idx32;
    logic [31:0]        rd_idx32;
    logic [IDX_W-1:0]   rd_idx;
    t_node              rd_node;
    t_node              step_node;
    logic [IDX_W-1:0]   child_idx;
    logic [CNT_W-1:0]   cnt_inc;
    logic               hit_leaf;

    // ---------------------------------------------------------------
    // Node table
    // ---------------------------------------------------------------
    assign wr_idx32  = 32'(i_node_index);
    assign ram_waddr = wr_idx32[AW-1:0];
    assign rd_idx32  = 32'(rd_idx);
    assign ram_raddr = rd_idx32[AW-1:0];
    assign n_rd_oob  = (rd_idx32 >= 32'(NODE_COUNT));

    hufd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (NODE_W'({i_node_is_leaf, i_left_index, i_right_index, i_leaf_symbol})),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // indexes past the table read as an empty node
    assign rd_node = r_rd_oob ? t_node'('0) : t_node'(ram_rdata);

    // ---------------------------------------------------------------
    // Config port
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[2];
    assign cfg_wr  = psel & penable & pwrite;
    assign prdata  = (cfg_idx == REG_ROOT) ? 32'(r_root) : r_total;

    // ---------------------------------------------------------------
    // Walk datapath: one child select per cycle
    // ---------------------------------------------------------------
    assign hit_leaf  = (r_state == ST_WALK) && rd_node.leaf;
    assign cnt_inc   = r_count + 32'd1;
    // after a leaf the walk restarts from the cached root node
    assign step_node = hit_leaf ? r_root_nd : rd_node;
    assign child_idx = ((r_byte & CODE_MSB) != '0) ? step_node.right : step_node.left;

    assign busy = (r_state != ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_walk      = r_walk;
        n_count     = r_count;
        n_root_nd   = r_root_nd;
        n_byte      = r_byte;
        n_bits      = r_bits;
        n_pend_v    = r_pend_v;
        n_pend_sym  = r_pend_sym;
        n_pend_done = r_pend_done;
        n_o_valid   = 1'b0;
        n_o_symbol  = r_pend_sym;
        n_o_last    = 1'b0;
        n_o_done    = r_pend_done;
        rd_idx      = r_walk;
        ram_we      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_operation == OP_LOAD) begin
                        ram_we = (wr_idx32 < 32'(NODE_COUNT));
                    end else begin
                        rd_idx  = r_root;
                        n_byte  = i_code_byte;
                        n_state = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                n_root_nd = rd_node;
                rd_idx    = r_walk;
                n_state   = (r_count == r_total) ? ST_IDLE : ST_CUR;
            end
            ST_CUR: begin
                rd_idx  = child_idx;
                n_walk  = child_idx;
                n_byte  = r_byte << 1;
                n_bits  = '0;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (hit_leaf) begin
                    n_count = cnt_inc;
                    n_walk  = r_root;
                    if (r_pend_v) begin
                        n_o_valid = 1'b1;
                    end
                    n_pend_v    = 1'b1;
                    n_pend_sym  = rd_node.sym;
                    n_pend_done = (cnt_inc == r_total);
                end
                if (r_bits == LAST_BIT || (hit_leaf && cnt_inc == r_total)) begin
                    n_state = ST_FLUSH;
                end else begin
                    rd_idx = child_idx;
                    n_walk = child_idx;
                    n_byte = r_byte << 1;
                    n_bits = r_bits + 1'b1;
                end
            end
            ST_FLUSH: begin
                n_o_valid = r_pend_v;
                n_o_last  = 1'b1;
                n_pend_v  = 1'b0;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (cfg_wr) begin
            n_walk  = (cfg_idx == REG_ROOT) ? pwdata[IDX_W-1:0] : r_root;
            n_count = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_root   <= '0;
            r_total  <= '0;
            r_walk   <= '0;
            r_count  <= '0;
            r_pend_v <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_walk   <= n_walk;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
            o_valid  <= n_o_valid;
            if (cfg_wr && cfg_idx == REG_ROOT) begin
                r_root <= pwdata[IDX_W-1:0];
            end
            if (cfg_wr && cfg_idx == REG_TOTAL) begin
                r_total <= pwdata;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_root_nd      <= n_root_nd;
        r_byte         <= n_byte;
        r_bits         <= n_bits;
        r_rd_oob       <= n_rd_oob;
        r_pend_sym     <= n_pend_sym;
        r_pend_done    <= n_pend_done;
        o_symbol       <= n_o_symbol;
        o_last_of_byte <= n_o_last;
        o_stream_done  <= n_o_done;
    end

endmodule

`default_nettype wire

[src/hufd_chk.sv]
// Port-level checker for the Huffman tree-walk decoder, bound to the top level.
// Depends on hufd_pkg and huffman_tree_walk_decoder.
`default_nettype none

module hufd_chk
    import hufd_pkg::*;
(
    input wire i_clk,
    input wire i_rst_n,
    input wire start,
    input wire busy,
    input wire i_operation,
    input wire o_valid,
    input wire o_last_of_byte,
    input wire o_stream_done
);

    // a node load never produces a beat
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_LOAD) |=> !o_valid)
        else $error("result beat after a node load");

    // an accepted decode always shows busy in the cycle after it is taken
    a_decode_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_DECODE) |=> busy)
        else $error("decode accepted without going busy");

    // beats only come out of a decode in progress
    a_beat_in_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result beat while idle");

    // the stream's final symbol closes its byte and nothing follows
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stream_done) |-> (o_last_of_byte ##1 !o_valid))
        else $error("stream end not last beat");

    // a beat that is not last of its byte has more work behind it
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_byte) |-> busy)
        else $error("non-final beat with block idle");

endmodule

bind huffman_tree_walk_decoder hufd_chk u_hufd_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_operation    (i_operation),
    .o_valid        (o_valid),
    .o_last_of_byte (o_last_of_byte),
    .o_stream_done  (o_stream_done)
);

`default_nettype wire
